// File: hdl/bmf_pkg.sv
// Shared types and constants for the edge-normalized box mean filter.
// No dependencies; every other file of the block imports this package.
package bmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 5;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int RAD_W = 3;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS       = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd512;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_FIN
  } bmf_state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic scan;
    logic drain;
    logic div;
    logic finish;
  } bmf_cmd_t;

  typedef struct packed {
    logic rad_even;
    logic out_due;
    logic win_last;
    logic div_done;
    logic out_free;
  } bmf_stat_t;

endpackage

// File: hdl/bmf_in_if.sv
// Input pixel channel of the box mean filter.
// Depends on bmf_pkg for the sample width.
interface bmf_in_if;
  import bmf_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] chan_blue;
  logic [PIX_W-1:0] chan_green;
  logic [PIX_W-1:0] chan_red;
  modport source(output valid, output req_type, output chan_blue, output chan_green,
                 output chan_red, input ready);
  modport sink(input valid, input req_type, input chan_blue, input chan_green,
               input chan_red, output ready);
endinterface

// File: hdl/bmf_out_if.sv
// Result channel of the box mean filter.
// Depends on bmf_pkg for the sample width.
interface bmf_out_if;
  import bmf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mean_blue;
  logic [PIX_W-1:0] mean_green;
  logic [PIX_W-1:0] mean_red;
  logic             frame_last;
  modport source(output valid, output mean_blue, output mean_green, output mean_red,
                 output frame_last, input ready);
  modport sink(input valid, input mean_blue, input mean_green, input mean_red,
               input frame_last, output ready);
endinterface

// File: hdl/bmf_cfg_if.sv
// Configuration write channel of the box mean filter.
// Depends on bmf_pkg for index and data widths.
interface bmf_cfg_if;
  import bmf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: hdl/bmf_ctrl.sv
// Sequencing state machine of the box mean filter.
// Depends on bmf_pkg for the state, command and status types.
module bmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmf_pkg::bmf_stat_t stat,
  output bmf_pkg::bmf_cmd_t  cmd
);
  import bmf_pkg::*;

  bmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // An even radius takes the item and stays idle; the stream position does not advance.
        if (in_valid && !stat.rad_even) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = stat.out_due ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.win_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_PREP:  cmd.prep   = 1'b1;
      ST_SCAN:  cmd.scan   = 1'b1;
      ST_DRAIN: cmd.drain  = 1'b1;
      ST_DIV:   cmd.div    = 1'b1;
      ST_FIN:   cmd.finish = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/bmf_datapath.sv
// Datapath of the box mean filter: configuration registers, history memory,
// window walk, accumulators, serial dividers and the output register. Uses bmf_pkg.
module bmf_datapath #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_req_type,
  input  logic [3*bmf_pkg::PIX_W-1:0] in_pix,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bmf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bmf_pkg::PIX_W-1:0]  out_mean_blue,
  output logic [bmf_pkg::PIX_W-1:0]  out_mean_green,
  output logic [bmf_pkg::PIX_W-1:0]  out_mean_red,
  output logic                       out_frame_last,
  input  bmf_pkg::bmf_cmd_t          cmd,
  output bmf_pkg::bmf_stat_t         stat
);
  import bmf_pkg::*;

  localparam int DEPTH   = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW      = $clog2(DEPTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int KW      = RW + 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int TW      = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                  + MAX_RADIUS + 1);
  localparam int SPW     = ((WW > HW) ? WW : HW) + 1;
  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW      = $clog2(WIN_MAX + 1);
  localparam int SW      = PIX_W + NW;
  localparam int DCW     = $clog2(SW);
  localparam int NCH     = 3;

  // Configuration registers and their clamped working values.
  logic [CFG_W-1:0] width_r, height_r;
  logic [RAD_W-1:0] radius_r;
  logic [WW-1:0]    w_c;
  logic [HW-1:0]    h_c;
  logic [RW-1:0]    r_c;

  always_comb begin
    if (width_r == '0)                w_c = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
    else                               w_c = WW'(width_r);
    if (height_r == '0)                 h_c = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
    else                                 h_c = HW'(height_r);
    if (32'(radius_r) > MAX_RADIUS) r_c = RW'(MAX_RADIUS);
    else                            r_c = RW'(radius_r);
  end

  logic cfg_fire;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      radius_r <= RADIUS_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_data;
        REG_FRAME_HEIGHT: height_r <= cfg_data;
        REG_RADIUS:       radius_r <= cfg_data[RAD_W-1:0];
        default: begin
          width_r <= width_r;
        end
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_fire && (cfg_index == REG_FRAME_WIDTH ||
                                cfg_index == REG_FRAME_HEIGHT ||
                                cfg_index == REG_RADIUS);

  // Latched item and per-item frame figures.
  logic                     pass_r;
  logic [3*PIX_W-1:0]       pix_r;
  logic [TW-1:0]            total_r, lag_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pass_r  <= !in_req_type;
      pix_r   <= in_pix;
      total_r <= TW'(w_c) * TW'(h_c);
      lag_r   <= TW'(r_c) * TW'(w_c) + TW'(r_c);
    end
  end

  // Stream position and output position.
  logic [TW-1:0]    t_r, p_r;
  logic [AW-1:0]    wr_ptr_r, slot_r;
  logic [COL_W-1:0] ocol_r;
  logic [ROW_W-1:0] orow_r;
  logic             last;

  assign last = (p_r + TW'(1)) >= total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r      <= '0;
      wr_ptr_r <= '0;
      p_r      <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
    end else if (cfg_hit || (cmd.finish && last)) begin
      t_r      <= '0;
      wr_ptr_r <= '0;
      p_r      <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
    end else begin
      if (cmd.prep) begin
        t_r      <= t_r + TW'(1);
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
      end
      if (cmd.finish) begin
        p_r <= p_r + TW'(1);
        if (32'(ocol_r) + 1 >= 32'(w_c)) begin
          ocol_r <= '0;
          orow_r <= orow_r + ROW_W'(1);
        end else begin
          ocol_r <= ocol_r + COL_W'(1);
        end
      end
    end
  end

  // Window walk: k over rows, l over columns, back is the distance into history.
  logic signed [KW-1:0]  k_r, l_r, r_s;
  logic [AW-1:0]         back_r, rd_addr;
  logic signed [SPW-1:0] rr, cc;
  logic                  in_win, win_last;

  assign r_s = $signed({1'b0, r_c});
  assign rr  = $signed(SPW'(orow_r)) + SPW'(k_r);
  assign cc  = $signed(SPW'(ocol_r)) + SPW'(l_r);
  assign in_win = (rr >= 0) && (rr < $signed(SPW'(h_c))) &&
                  (cc >= 0) && (cc < $signed(SPW'(w_c)));
  assign win_last = (k_r == r_s) && (l_r == r_s);
  // Modular address; wraps correctly even when the depth is a power of two.
  assign rd_addr = (slot_r >= back_r) ? slot_r - back_r
                                      : AW'(DEPTH) + slot_r - back_r;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      slot_r <= wr_ptr_r;
      k_r    <= -r_s;
      l_r    <= -r_s;
      back_r <= AW'({lag_r, 1'b0});
    end else if (cmd.scan) begin
      if (l_r == r_s) begin
        l_r    <= -r_s;
        k_r    <= k_r + KW'(1);
        back_r <= back_r - AW'(w_c) + AW'({r_c, 1'b0});
      end else begin
        l_r    <= l_r + KW'(1);
        back_r <= back_r - AW'(1);
      end
    end
  end

  // History memory of recent pixels.
  logic [3*PIX_W-1:0] mem [DEPTH];
  logic [3*PIX_W-1:0] rdata_r, wdata;
  logic               take_r;

  assign wdata = (pass_r && t_r < total_r) ? pix_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.prep) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) take_r <= 1'b0;
    else        take_r <= cmd.scan && in_win;
  end

  // Accumulators double as quotient registers of the restoring dividers.
  logic [SW-1:0]  acc_r [NCH];
  logic [NW-1:0]  rem_r [NCH];
  logic [NW-1:0]  cnt_r;
  logic [DCW-1:0] div_cnt_r;
  logic [NW:0]    shifted [NCH];
  logic           qbit [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      shifted[c] = {rem_r[c], acc_r[c][SW-1]};
      qbit[c]    = shifted[c] >= {1'b0, cnt_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cnt_r <= '0;
      for (int c = 0; c < NCH; c++) acc_r[c] <= '0;
    end else begin
      if (cmd.scan && in_win) cnt_r <= cnt_r + NW'(1);
      if (take_r) begin
        for (int c = 0; c < NCH; c++)
          acc_r[c] <= acc_r[c] + SW'(rdata_r[c*PIX_W +: PIX_W]);
      end else if (cmd.div) begin
        for (int c = 0; c < NCH; c++)
          acc_r[c] <= {acc_r[c][SW-2:0], qbit[c]};
      end
    end
    if (cmd.drain) begin
      div_cnt_r <= '0;
      for (int c = 0; c < NCH; c++) rem_r[c] <= '0;
    end else if (cmd.div) begin
      div_cnt_r <= div_cnt_r + DCW'(1);
      for (int c = 0; c < NCH; c++)
        rem_r[c] <= qbit[c] ? NW'(shifted[c] - {1'b0, cnt_r}) : NW'(shifted[c]);
    end
  end

  // Output register; the center position is always in frame so the count is nonzero.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_mean_blue  <= acc_r[0][PIX_W-1:0];
      out_mean_green <= acc_r[1][PIX_W-1:0];
      out_mean_red   <= acc_r[2][PIX_W-1:0];
      out_frame_last <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.rad_even = !r_c[0];
  assign stat.out_due  = t_r >= lag_r;
  assign stat.win_last = win_last;
  assign stat.div_done = 32'(div_cnt_r) == SW - 1;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// File: hdl/edge_normalized_box_mean_filter.sv
// Box mean filter over RGB pixels with frame-edge normalization.
// Top level; instantiates bmf_ctrl and bmf_datapath, uses bmf_pkg and the channel interfaces.
//
// Usage: pixels enter in raster order on in_ch; each transfer is one item. After
// radius*width+radius items each item yields one result on out_ch: the truncated
// per-channel mean over the in-frame part of the square window. After the frame the
// host sends radius*width+radius flush items; frame_last marks the final result.
// With an even radius items are taken and give no result.
// Registers are to be written on cfg_ch (index 0 width, 1 height, 2 radius) only while the
// block is idle; the block does not enforce this. A write to one of them restarts the frame.
// Flow: one item at a time; the block takes no new item until it is through with the
// last. An item with a result walks the window, one history-memory read a cycle, then
// runs the bit-serial division over SW bits (SW is 15 at the default sizes). The result
// shows on out_ch after the division and stays until taken; the next item is accepted
// while it waits, and only a second finished result waits on a stalled receiver.
// Synchronous reset clears the stream position, restores the register defaults and
// empties the output; history memory is not cleared.
module edge_normalized_box_mean_filter #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bmf_in_if.sink    in_ch,
  bmf_out_if.source out_ch,
  bmf_cfg_if.sink   cfg_ch
);
  import bmf_pkg::*;

  bmf_cmd_t  cmd;
  bmf_stat_t stat;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_ch.req_type),
    .in_pix         ({in_ch.chan_red, in_ch.chan_green, in_ch.chan_blue}),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_mean_blue  (out_ch.mean_blue),
    .out_mean_green (out_ch.mean_green),
    .out_mean_red   (out_ch.mean_red),
    .out_frame_last (out_ch.frame_last),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// File: hdl/bmf_checker.sv
// Port-level assertions for the box mean filter, bound to the top level.
// Depends on bmf_pkg for field widths.
module bmf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bmf_pkg::PIX_W-1:0] out_mean_blue,
  input logic [bmf_pkg::PIX_W-1:0] out_mean_green,
  input logic [bmf_pkg::PIX_W-1:0] out_mean_red,
  input logic                      out_frame_last
);
  import bmf_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_blue) &&
      $stable(out_mean_green) && $stable(out_mean_red) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A result needs the window walk and the division; it never follows a transfer directly.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared right after an input transfer");

endmodule

bind edge_normalized_box_mean_filter bmf_checker u_bmf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_mean_blue  (out_ch.mean_blue),
  .out_mean_green (out_ch.mean_green),
  .out_mean_red   (out_ch.mean_red),
  .out_frame_last (out_ch.frame_last)
);

// File: tb/bmf_tb_if.sv
// Testbench-side view of the three filter channels.
// Depends on bmf_pkg.
// The block's own interfaces are used as they are; this file holds the channel item type.
package bmf_tb_pkg;
  import bmf_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;
  } mean_pix_t;
endpackage

// File: tb/tb.sv
// Self-checking bench for edge_normalized_box_mean_filter.
// Depends on bmf_pkg, bmf_tb_pkg and the channel interfaces; predicts each mean in a class.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmf_pkg::*;
  import bmf_tb_pkg::*;

  // An index past the register list; writes to it are ignored.
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  class box_mean_predictor;
    int unsigned width_reg, height_reg, radius_reg;
    int unsigned in_row, in_col, out_idx;
    logic [23:0] frame_pix[int];
    mean_pix_t   expected_means[$];
    int          errors, means_checked, pixels_sent;

    function new();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      radius_reg = RADIUS_RESET;
      restart();
    endfunction

    function void restart();
      in_row = 0;
      in_col = 0;
      out_idx = 0;
      frame_pix.delete();
    endfunction

    function int unsigned eff_w();
      return (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
    endfunction

    function int unsigned eff_h();
      return (height_reg == 0) ? 1 : (height_reg > 1024 ? 1024 : height_reg);
    endfunction

    function int unsigned eff_r();
      return (radius_reg > 5) ? 5 : radius_reg;
    endfunction

    function void note_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        REG_RADIUS: radius_reg = data[RAD_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    function void note_pixel(logic req, logic [7:0] b, logic [7:0] g, logic [7:0] rd);
      int unsigned w, h, r, total, t, lag, orow, ocol, cnt;
      int unsigned sb, sg, sr;
      int rr, cc;
      logic [23:0] px;
      mean_pix_t m;
      w = eff_w();
      h = eff_h();
      r = eff_r();
      pixels_sent++;
      if (r[0] == 1'b0) return;
      total = w * h;
      t = in_row * w + in_col;
      // Flush items and anything past the frame end are stored as black.
      frame_pix[t] = (req == 1'b0 && t < total) ? {b, g, rd} : 24'd0;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      lag = r * w + r;
      if (t < lag) return;
      orow = out_idx / w;
      ocol = out_idx % w;
      sb = 0; sg = 0; sr = 0; cnt = 0;
      for (int k = -int'(r); k <= int'(r); k++) begin
        rr = int'(orow) + k;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int l = -int'(r); l <= int'(r); l++) begin
          cc = int'(ocol) + l;
          if (cc < 0 || cc >= int'(w)) continue;
          px = frame_pix[rr * int'(w) + cc];
          sb += px[23:16];
          sg += px[15:8];
          sr += px[7:0];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      m.blue = 8'(sb / cnt);
      m.green = 8'(sg / cnt);
      m.red = 8'(sr / cnt);
      m.last = (out_idx + 1 >= total);
      expected_means.push_back(m);
      out_idx++;
      if (m.last) restart();
    endfunction

    function void check_mean(mean_pix_t got);
      mean_pix_t e;
      means_checked++;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result b=%0d g=%0d r=%0d last=%0b", $time,
                 got.blue, got.green, got.red, got.last);
        errors++;
        return;
      end
      e = expected_means.pop_front();
      if (got.blue !== e.blue) begin
        $display("%0t: mean_blue expected %0d actual %0d", $time, e.blue, got.blue);
        errors++;
      end
      if (got.green !== e.green) begin
        $display("%0t: mean_green expected %0d actual %0d", $time, e.green, got.green);
        errors++;
      end
      if (got.red !== e.red) begin
        $display("%0t: mean_red expected %0d actual %0d", $time, e.red, got.red);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  box_mean_predictor predictor;

  bmf_in_if  in_ch();
  bmf_out_if out_ch();
  bmf_cfg_if cfg_ch();

  edge_normalized_box_mean_filter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls before each transfer, none during burst stretches.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    mean_pix_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.blue = out_ch.mean_blue;
      got.green = out_ch.mean_green;
      got.red = out_ch.mean_red;
      got.last = out_ch.frame_last;
      predictor.check_mean(got);
    end
  end

  task automatic send_pixel(logic req, logic [7:0] b, logic [7:0] g, logic [7:0] rd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.chan_blue <= b;
    in_ch.chan_green <= g;
    in_ch.chan_red <= rd;
    do @(posedge clk); while (!in_ch.ready);
    predictor.note_pixel(req, b, g, rd);
  endtask

  // Waits for every pending mean plus enough cycles for a result-free item in flight.
  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (predictor.expected_means.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    predictor.note_config(idx, data);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [RAD_W-1:0] r);
    drain_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  // The first n pixels of a large frame; the next configuration starts over.
  task automatic run_partial(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end
  endtask

  // One frame of random pixels followed by its flush items (3 to 12 items with an even
  // radius); noise_pct of items have their type flipped, and a cut frame stops early.
  task automatic run_frame(int noise_pct, bit cut, bit extreme_px);
    int unsigned n, r;
    logic req;
    logic [7:0] b, g, rd;
    r = predictor.eff_r();
    n = predictor.eff_w() * predictor.eff_h();
    if (r[0]) n += r * predictor.eff_w() + r;
    else n = $urandom_range(3, 12);
    if (cut) n = $urandom_range(1, n);
    for (int unsigned i = 0; i < n; i++) begin
      req = (i >= predictor.eff_w() * predictor.eff_h());
      if ($urandom_range(0, 99) < noise_pct) req = ~req;
      if (extreme_px) begin
        b = $urandom_range(0, 1) ? 8'hff : 8'h00;
        g = $urandom_range(0, 1) ? 8'hff : 8'h00;
        rd = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end else begin
        b = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        rd = 8'($urandom_range(0, 255));
      end
      send_pixel(req, b, g, rd);
    end
  endtask

  initial begin
    predictor = new();
    rst_n <= 1'b0;
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= 1'b0;
    in_ch.chan_blue <= '0;
    in_ch.chan_green <= '0;
    in_ch.chan_red <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_FRAME_WIDTH;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small frame with saturated pixels and flushes inside the frame,
    // zero width and height, even radii, out-of-range index, then the size and radius extremes.
    set_frame(11'd3, 11'd3, 3'd1);
    run_frame(20, 1'b0, 1'b1);
    set_frame(11'd0, 11'd4, 3'd1);
    run_frame(0, 1'b0, 1'b1);
    set_frame(11'd4, 11'd0, 3'd3);
    run_frame(0, 1'b0, 1'b0);
    set_frame(11'd3, 11'd3, 3'd0);
    run_frame(0, 1'b0, 1'b0);
    set_frame(11'd3, 11'd3, 3'd2);
    run_frame(0, 1'b0, 1'b0);
    drain_idle();
    write_reg(REG_UNUSED, 11'h7ff);
    set_frame(11'd2, 11'd2, 3'd7);
    run_frame(0, 1'b0, 1'b1);
    set_frame(11'd2047, 11'd1, 3'd1);
    run_partial(30);
    set_frame(11'd1, 11'd2047, 3'd6);
    no_idle = 1'b1;
    run_partial(60);
    no_idle = 1'b0;
    set_frame(11'd1024, 11'd1, 3'd5);
    run_partial(30);

    // Random: mostly complete frames of small sizes, some noisy or cut short.
    while (predictor.pixels_sent < 700) begin
      set_frame(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 6)),
                RAD_W'($urandom_range(0, 7)));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 9))
          0: run_frame(15, 1'b0, 1'b0);
          1: run_frame(0, 1'b1, 1'b0);
          2: run_frame(0, 1'b0, 1'b1);
          default: run_frame(0, 1'b0, 1'b0);
        endcase
      end
      no_idle = 1'b0;
    end
    drain_idle();

    $display("Sent %0d pixel and flush items over many frame shapes and radii;",
             predictor.pixels_sent);
    $display("checked %0d window means.", predictor.means_checked);
    if (predictor.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/bmf_pkg.sv
hdl/bmf_in_if.sv
hdl/bmf_out_if.sv
hdl/bmf_cfg_if.sv
hdl/bmf_ctrl.sv
hdl/bmf_datapath.sv
hdl/edge_normalized_box_mean_filter.sv
hdl/bmf_checker.sv
tb/bmf_tb_if.sv
tb/tb.sv
